>>> hdl/assert_macros.svh
// assertion macros used by the checker file
// needs a clock and an active-low reset name at each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/prap_pkg.sv
// shared types, codes and constants of the paged ram pointer port
// no dependencies
package prap_pkg;

    // storage geometry
    localparam int RAM_ADDR_BITS = 23;
    localparam int REG_COUNT     = 16;
    localparam int REG_IDX_BITS  = 4;
    localparam int PTR_BITS      = 24;
    localparam int MASK_BITS     = 23;
    localparam int DATA_BITS     = 8;
    localparam int SLOT_BITS     = 3;
    localparam int ROM_ADDR_BITS = 13;
    localparam int OFFSET_BITS   = 11;

    // stream and bus widths
    localparam int S_TDATA_BITS  = 24;
    localparam int S_TUSER_BITS  = 2;
    localparam int M_TDATA_BITS  = 24;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    // rom address offsets
    localparam logic [ROM_ADDR_BITS-1:0] SLOT_BANK_OFS = 13'h1000;
    localparam logic [ROM_ADDR_BITS-1:0] SHARED_LO_OFS = 13'h0800;
    localparam logic [ROM_ADDR_BITS-1:0] SHARED_HI_OFS = 13'h1800;

    // power-up ram contents
    localparam logic [DATA_BITS-1:0] FILL_BYTE = 8'hFF;

    // configuration reset values
    localparam logic                 RST_EXT       = 1'b0;
    localparam logic [7:0]           RST_BANK_HI   = 8'hF0;
    localparam logic [MASK_BITS-1:0] RST_ADDR_MASK = 23'h0FFFFF;
    localparam logic [SLOT_BITS-1:0] RST_SLOT      = 3'd1;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_EXT     = 2'd0;
    localparam logic [1:0] CFG_IDX_BANK_HI = 2'd1;
    localparam logic [1:0] CFG_IDX_MASK    = 2'd2;
    localparam logic [1:0] CFG_IDX_SLOT    = 2'd3;

    // register window indexes
    localparam logic [REG_IDX_BITS-1:0] REG_PTR_LO   = 4'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PTR_MID  = 4'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_PTR_HI   = 4'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_RAM_DATA = 4'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_BANK_SEL = 4'd15;

    // request kinds carried in tuser
    typedef enum logic [S_TUSER_BITS-1:0] {
        REQ_REG_RD     = 2'd0,
        REQ_REG_WR     = 2'd1,
        REQ_SLOT_ROM   = 2'd2,
        REQ_SHARED_ROM = 2'd3
    } req_t;

    // control state of the core
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    // configuration seen by the core
    typedef struct packed {
        logic                 ext;
        logic [7:0]           bank_hi;
        logic [MASK_BITS-1:0] addr_mask;
        logic [SLOT_BITS-1:0] slot;
    } cfg_t;

endpackage

>>> hdl/prap_ram.sv
// generic single-port synchronous ram, registered read data
// no dependencies
module prap_ram #(
    parameter int ADDR_BITS = 23,
    parameter int DATA_BITS = 8
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [DATA_BITS-1:0] wdata,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[addr];
    end

endmodule

>>> hdl/prap_cfg.sv
// apb configuration registers of the paged ram pointer port
// depends on prap_pkg
module prap_cfg (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [prap_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [prap_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [prap_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready,
    output prap_pkg::cfg_t                         cfg
);

    prap_pkg::cfg_t cfg_reg;
    prap_pkg::cfg_t cfg_next;
    logic [1:0]     idx;
    logic           wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                prap_pkg::CFG_IDX_EXT:     cfg_next.ext       = pwdata[0];
                prap_pkg::CFG_IDX_BANK_HI: cfg_next.bank_hi   = pwdata[7:0];
                prap_pkg::CFG_IDX_MASK:
                    cfg_next.addr_mask = pwdata[prap_pkg::MASK_BITS-1:0];
                prap_pkg::CFG_IDX_SLOT:
                    cfg_next.slot      = pwdata[prap_pkg::SLOT_BITS-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ext       <= prap_pkg::RST_EXT;
            cfg_reg.bank_hi   <= prap_pkg::RST_BANK_HI;
            cfg_reg.addr_mask <= prap_pkg::RST_ADDR_MASK;
            cfg_reg.slot      <= prap_pkg::RST_SLOT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back mux
    always_comb
    begin
        case (idx)
            prap_pkg::CFG_IDX_EXT:
                prdata = prap_pkg::APB_DATA_BITS'(cfg_reg.ext);
            prap_pkg::CFG_IDX_BANK_HI:
                prdata = prap_pkg::APB_DATA_BITS'(cfg_reg.bank_hi);
            prap_pkg::CFG_IDX_MASK:
                prdata = prap_pkg::APB_DATA_BITS'(cfg_reg.addr_mask);
            prap_pkg::CFG_IDX_SLOT:
                prdata = prap_pkg::APB_DATA_BITS'(cfg_reg.slot);
            default:
                prdata = '0;
        endcase
    end

endmodule

>>> hdl/paged_ram_autoinc_pointer_port_core.sv
// Results: register, pointer and rom requests give their beat the cycle after accept; a
// ram read through the data register passes the ram read register and the pend register.
// Throughput: 1 item per cycle unless the output stalls or a ram read is pending.
// Reset: registers and pointers clear; the ram is then swept to 0xFF, one byte per cycle,
// over all 2**23 addresses, taking no input beat; configuration writes work throughout.
// depends on prap_pkg, prap_ram, prap_cfg
module paged_ram_autoinc_pointer_port_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input beats
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // offset [10:0], write_data [18:11], zero [23:19]
    input  logic [prap_pkg::S_TDATA_BITS-1:0]      s_axis_tdata,
    // req_type [1:0]
    input  logic [prap_pkg::S_TUSER_BITS-1:0]      s_axis_tuser,
    // result beats
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // read_data [7:0], rom_address [20:8], zero [23:21]
    output logic [prap_pkg::M_TDATA_BITS-1:0]      m_axis_tdata,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [prap_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [prap_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [prap_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);

    localparam int NA = prap_pkg::RAM_ADDR_BITS;
    localparam int DB = prap_pkg::DATA_BITS;
    localparam int PB = prap_pkg::PTR_BITS;
    localparam int RB = prap_pkg::ROM_ADDR_BITS;

    prap_pkg::cfg_t   cfg;
    prap_pkg::state_t state_reg;
    prap_pkg::state_t state_next;
    logic [NA-1:0]    clr_cnt_reg;
    logic [NA-1:0]    clr_cnt_next;

    logic [DB-1:0]    reg_file_reg  [prap_pkg::REG_COUNT];
    logic [DB-1:0]    reg_file_next [prap_pkg::REG_COUNT];
    logic [PB-1:0]    wr_ptr_reg;
    logic [PB-1:0]    wr_ptr_next;
    logic [PB-1:0]    live_ptr_reg;
    logic [PB-1:0]    live_ptr_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [DB-1:0]    out_rd_reg;
    logic [DB-1:0]    out_rd_next;
    logic [RB-1:0]    out_rom_reg;
    logic [RB-1:0]    out_rom_next;
    logic             pend_reg;
    logic             pend_next;

    logic                                    accept;
    logic                                    clearing;
    logic [prap_pkg::OFFSET_BITS-1:0]        off;
    logic [DB-1:0]                           wdat;
    logic [prap_pkg::REG_IDX_BITS-1:0]       ridx;
    logic                                    is_rd;
    logic                                    is_wr;
    logic                                    ram_rd;
    logic                                    ram_wr;
    logic                                    bank_sel;
    logic [PB-1:0]                           masked_ptr;
    logic [PB-1:0]                           ptr_inc;
    logic [RB-1:0]                           slot_rom;
    logic [RB-1:0]                           shared_rom;
    logic                                    ram_we;
    logic [NA-1:0]                           ram_addr;
    logic [DB-1:0]                           ram_wdata;
    logic [DB-1:0]                           ram_rdata;
    logic                                    show_upd;
    logic [PB-1:0]                           show_ptr;

    // configuration registers
    prap_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // beat fields
    assign off  = s_axis_tdata[prap_pkg::OFFSET_BITS-1:0];
    assign wdat = s_axis_tdata[prap_pkg::OFFSET_BITS +: DB];
    assign ridx = off[prap_pkg::REG_IDX_BITS-1:0];

    assign clearing      = (state_reg == prap_pkg::ST_CLEAR);
    assign s_axis_tready = !clearing && !pend_reg && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign is_rd  = (s_axis_tuser == prap_pkg::REQ_REG_RD);
    assign is_wr  = (s_axis_tuser == prap_pkg::REQ_REG_WR);
    assign ram_rd = accept && is_rd && (ridx == prap_pkg::REG_RAM_DATA);
    assign ram_wr = accept && is_wr && (ridx == prap_pkg::REG_RAM_DATA);

    // ram address from the masked live pointer
    assign masked_ptr = live_ptr_reg & {{(PB - prap_pkg::MASK_BITS){1'b0}}, cfg.addr_mask};
    assign ptr_inc    = live_ptr_reg + PB'(1);

    // rom addresses
    assign bank_sel   = cfg.ext && reg_file_reg[prap_pkg::REG_BANK_SEL][0];
    assign slot_rom   = RB'({cfg.slot, off[7:0]})
                      + (bank_sel ? prap_pkg::SLOT_BANK_OFS : RB'(0));
    assign shared_rom = RB'(off)
                      + (bank_sel ? prap_pkg::SHARED_HI_OFS : prap_pkg::SHARED_LO_OFS);

    // ram port: clearing sweep or data register access
    assign ram_we    = clearing || ram_wr;
    assign ram_addr  = clearing ? clr_cnt_reg : masked_ptr[NA-1:0];
    assign ram_wdata = clearing ? prap_pkg::FILL_BYTE : wdat;

    prap_ram #(
        .ADDR_BITS (NA),
        .DATA_BITS (DB)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // clearing sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            prap_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + NA'(1);
                if (&clr_cnt_reg)
                begin
                    state_next = prap_pkg::ST_RUN;
                end
            end
            prap_pkg::ST_RUN:
            begin
                state_next = prap_pkg::ST_RUN;
            end
            default:
            begin
                state_next = prap_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= prap_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // pointer and register window update
    always_comb
    begin
        reg_file_next = reg_file_reg;
        wr_ptr_next   = wr_ptr_reg;
        live_ptr_next = live_ptr_reg;
        show_upd      = 1'b0;
        show_ptr      = wr_ptr_reg;
        if (accept && (ram_rd || ram_wr))
        begin
            live_ptr_next = ptr_inc;
            show_upd      = 1'b1;
            show_ptr      = ptr_inc;
        end
        else if (accept && is_wr)
        begin
            case (ridx)
                prap_pkg::REG_PTR_LO:
                begin
                    wr_ptr_next[7:0] = wdat;
                    show_upd         = 1'b1;
                end
                prap_pkg::REG_PTR_MID:
                begin
                    wr_ptr_next[15:8] = wdat;
                    show_upd          = 1'b1;
                end
                prap_pkg::REG_PTR_HI:
                begin
                    wr_ptr_next[23:16] = wdat;
                    show_upd           = 1'b1;
                end
                default:
                begin
                    reg_file_next[ridx] = wdat;
                end
            endcase
            if (show_upd)
            begin
                live_ptr_next = wr_ptr_next;
                show_ptr      = wr_ptr_next;
            end
        end
        if (show_upd)
        begin
            reg_file_next[prap_pkg::REG_PTR_LO]  = show_ptr[7:0];
            reg_file_next[prap_pkg::REG_PTR_MID] = show_ptr[15:8];
            reg_file_next[prap_pkg::REG_PTR_HI]  = show_ptr[23:16] | cfg.bank_hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < prap_pkg::REG_COUNT; i++)
            begin
                reg_file_reg[i] <= '0;
            end
            wr_ptr_reg   <= '0;
            live_ptr_reg <= '0;
        end
        else
        begin
            reg_file_reg <= reg_file_next;
            wr_ptr_reg   <= wr_ptr_next;
            live_ptr_reg <= live_ptr_next;
        end
    end

    // result register, ram reads land after a pending stage
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rd_next    = out_rd_reg;
        out_rom_next   = out_rom_reg;
        pend_next      = 1'b0;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
            out_rd_next    = ram_rdata;
            out_rom_next   = '0;
        end
        else if (ram_rd)
        begin
            pend_next = 1'b1;
        end
        else if (accept)
        begin
            out_valid_next = 1'b1;
            out_rd_next    = '0;
            out_rom_next   = '0;
            case (s_axis_tuser)
                prap_pkg::REQ_REG_RD:     out_rd_next  = reg_file_reg[ridx];
                prap_pkg::REQ_REG_WR:     out_rd_next  = '0;
                prap_pkg::REQ_SLOT_ROM:   out_rom_next = slot_rom;
                prap_pkg::REQ_SHARED_ROM: out_rom_next = shared_rom;
                default:                  out_rom_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rd_reg  <= out_rd_next;
        out_rom_reg <= out_rom_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = prap_pkg::M_TDATA_BITS'({out_rom_reg, out_rd_reg});

endmodule

>>> hdl/prap_checker.sv
// port-level checks of the paged ram pointer port, bound to the top level
// depends on prap_pkg and assert_macros.svh
`include "assert_macros.svh"

module prap_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic [prap_pkg::S_TDATA_BITS-1:0]      s_axis_tdata,
    input logic [prap_pkg::S_TUSER_BITS-1:0]      s_axis_tuser,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [prap_pkg::M_TDATA_BITS-1:0]      m_axis_tdata
);

    logic in_beat;
    logic wr_beat;
    logic rom_beat;
    logic out_stall;
    logic out_zero_rd;

    assign in_beat     = s_axis_tvalid && s_axis_tready;
    assign wr_beat     = in_beat && (s_axis_tuser == prap_pkg::REQ_REG_WR);
    assign rom_beat    = in_beat && ((s_axis_tuser == prap_pkg::REQ_SLOT_ROM)
                                  || (s_axis_tuser == prap_pkg::REQ_SHARED_ROM));
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_zero_rd = m_axis_tvalid && (m_axis_tdata[7:0] == 8'd0);

    // a stalled result beat stays and holds its data
    `AST_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid, "result beat dropped while stalled")
    `AST_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(m_axis_tdata), "stalled data changed")

    // padding above the result fields is zero
    `AST_SAME(a_out_pad, clk, rst_n, m_axis_tvalid, m_axis_tdata[23:21] == 3'd0, "padding not zero")

    // a register write gives its beat next cycle with no read data
    `AST_NEXT(a_wr_result, clk, rst_n, wr_beat, out_zero_rd, "register write result missing")

    // a rom read gives its beat next cycle with no read data
    `AST_NEXT(a_rom_result, clk, rst_n, rom_beat, out_zero_rd, "rom read result missing")

endmodule

bind paged_ram_autoinc_pointer_port_core prap_checker u_prap_checker (.*);
